>>> rtl/core/assert_macros.svh
// Assertion macros shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define IAR_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("iar assertion failed");

`define IAR_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("iar assertion failed");

`else

`define IAR_ASSERT(lbl, prop)

`define IAR_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

>>> rtl/core/iar_pkg.sv
`default_nettype none

package iar_pkg;

  localparam int unsigned ValueW    = 64;
  localparam int unsigned WidthW    = 6;
  localparam int unsigned CharW     = 8;
  localparam int unsigned DigitW    = 4;
  localparam int unsigned NumDigits = 22;
  localparam int unsigned BcdW      = NumDigits * DigitW;
  localparam int unsigned OctW      = NumDigits * 3;
  localparam int unsigned HexDigits = ValueW / DigitW;
  localparam int unsigned NdigW     = 5;
  localparam int unsigned DecSteps  = ValueW / 2;
  localparam int unsigned StepCntW  = 5;
  localparam int unsigned QDepth    = 2;
  localparam int unsigned QPtrW     = 1;
  localparam int unsigned QCntW     = 2;

  localparam logic [CharW-1:0]  CharZero   = 8'h30;
  localparam logic [CharW-1:0]  CharLowA   = 8'h61;
  localparam logic [CharW-1:0]  CharUpA    = 8'h41;
  localparam logic [CharW-1:0]  CharMinus  = 8'h2d;
  localparam logic [DigitW-1:0] DigitNine  = 4'd9;
  localparam logic [DigitW-1:0] DigitTen   = 4'd10;
  localparam logic [DigitW-1:0] DabbleLim  = 4'd5;
  localparam logic [DigitW-1:0] DabbleAdd  = 4'd3;

  typedef enum logic [1:0] {
    OP_SDEC = 2'd0,
    OP_UDEC = 2'd1,
    OP_HEX  = 2'd2,
    OP_OCT  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    F_IDLE,
    F_CONV,
    F_PUSH
  } front_state_e;

  typedef enum logic [1:0] {
    B_IDLE,
    B_PAD,
    B_SIGN,
    B_DIGIT
  } back_state_e;

  typedef logic [NumDigits-1:0][DigitW-1:0] digits_t;

  typedef struct packed {
    digits_t           digits;
    logic [NdigW-1:0]  ndig;
    logic              neg;
    logic              upper;
    logic [CharW-1:0]  fill_char;
    logic [WidthW-1:0] width;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  function automatic logic [CharW-1:0] digit_char(logic [DigitW-1:0] d, logic upper);
    logic [CharW-1:0] res;
    if (d > DigitNine) begin
      res = CharW'(d - DigitTen) + (upper ? CharUpA : CharLowA);
    end else begin
      res = CharZero + CharW'(d);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/iar_front.sv
`default_nettype none

module iar_front import iar_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        op_i,
  input  wire logic [ValueW-1:0] value_i,
  input  wire logic [WidthW-1:0] min_width_i,
  input  wire logic [CharW-1:0]  fill_char_i,
  input  wire logic              upper_hex_i,
  input  wire qstat_t            qstat_i,
  output logic                   push_o,
  output entry_t                 entry_o
);

  localparam logic [WidthW:0] MaxW = (WidthW + 1)'(MAX_WIDTH);

  front_state_e          state_q, state_d;
  logic [StepCntW-1:0]   cnt_q, cnt_d;
  logic [ValueW-1:0]     mag_q;
  digits_t               digits_q;
  logic                  neg_q;
  logic                  upper_q;
  logic [CharW-1:0]      pad_q;
  logic [WidthW-1:0]     width_q;

  op_e                   op;
  logic                  is_dec;
  logic                  load;
  logic                  neg_in;
  logic [ValueW-1:0]     mag_in;
  logic [WidthW-1:0]     width_in;
  digits_t               radix_digits;
  logic [OctW-1:0]       oct_ext;
  logic [BcdW-1:0]       hex_ext;
  logic [BcdW-1:0]       bcd;
  logic [ValueW-1:0]     sh;
  logic [NdigW-1:0]      ndig;

  assign op     = op_e'(op_i);
  assign is_dec = op inside {OP_SDEC, OP_UDEC};
  assign load   = (state_q == F_IDLE) && in_valid_i;

  always_comb begin
    state_d = state_q;
    case (state_q)
      F_IDLE: begin
        if (in_valid_i) begin
          state_d = is_dec ? F_CONV : F_PUSH;
        end
      end
      F_CONV: begin
        if (cnt_q == StepCntW'(DecSteps - 1)) begin
          state_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!qstat_i.full) begin
          state_d = F_IDLE;
        end
      end
      default: state_d = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = (state_q == F_IDLE);
    push_o     = (state_q == F_PUSH) && !qstat_i.full;
    cnt_d      = cnt_q;
    if (load) begin
      cnt_d = '0;
    end else if (state_q == F_CONV) begin
      cnt_d = cnt_q + StepCntW'(1);
    end
  end

  always_comb begin
    neg_in   = (op == OP_SDEC) && value_i[ValueW-1];
    mag_in   = neg_in ? (~value_i + ValueW'(1)) : value_i;
    width_in = ({1'b0, min_width_i} > MaxW) ? WidthW'(MaxW) : min_width_i;
    oct_ext  = OctW'(mag_in);
    hex_ext  = BcdW'(mag_in);
    for (int i = 0; i < NumDigits; i++) begin
      if (op == OP_HEX) begin
        radix_digits[i] = (i < HexDigits) ? hex_ext[i*DigitW +: DigitW] : '0;
      end else begin
        radix_digits[i] = {1'b0, oct_ext[i*3 +: 3]};
      end
    end
  end

  // two shift-add-3 steps per cycle
  always_comb begin
    bcd = BcdW'(digits_q);
    sh  = mag_q;
    for (int s = 0; s < 2; s++) begin
      for (int i = 0; i < NumDigits; i++) begin
        if (bcd[i*DigitW +: DigitW] >= DabbleLim) begin
          bcd[i*DigitW +: DigitW] = bcd[i*DigitW +: DigitW] + DabbleAdd;
        end
      end
      bcd = {bcd[BcdW-2:0], sh[ValueW-1]};
      sh  = {sh[ValueW-2:0], 1'b0};
    end
  end

  always_comb begin
    ndig = NdigW'(1);
    for (int i = 0; i < NumDigits; i++) begin
      if (digits_q[i] != '0) begin
        ndig = NdigW'(i + 1);
      end
    end
  end

  assign entry_o = '{digits: digits_q, ndig: ndig, neg: neg_q, upper: upper_q,
                     fill_char: pad_q, width: width_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= F_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      neg_q    <= neg_in;
      upper_q  <= upper_hex_i;
      pad_q    <= fill_char_i;
      width_q  <= width_in;
      mag_q    <= mag_in;
      digits_q <= is_dec ? digits_t'('0) : radix_digits;
    end else if (state_q == F_CONV) begin
      mag_q    <= sh;
      digits_q <= digits_t'(bcd);
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/iar_fifo.sv
`default_nettype none

module iar_fifo import iar_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  wire entry_t entry_i,
  input  wire logic   pop_i,
  output entry_t      entry_o,
  output qstat_t      qstat_o
);

  entry_t            mem_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q;
  logic [QPtrW-1:0]  rd_ptr_q;
  logic [QCntW-1:0]  cnt_q;

  assign entry_o       = mem_q[rd_ptr_q];
  assign qstat_o.full  = (cnt_q == QCntW'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + QCntW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - QCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/iar_back.sv
`default_nettype none

module iar_back import iar_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire qstat_t           qstat_i,
  output logic                  pop_o,
  input  wire entry_t           entry_i,
  output logic                  out_valid_o,
  input  wire logic             out_ready_i,
  output logic [CharW-1:0]      out_char_o,
  output logic                  out_last_o
);

  localparam int unsigned PadCntW = $clog2(MAX_WIDTH + 1);

  back_state_e          state_q, state_d;
  entry_t               cur_q;
  logic [PadCntW-1:0]   pad_cnt_q;
  logic [NdigW-1:0]     idx_q;
  logic                 out_valid_q;
  logic [CharW-1:0]     out_char_q;
  logic                 out_last_q;

  logic                 out_free;
  logic                 emit;
  logic [CharW-1:0]     char_d;
  logic                 last_d;
  logic [WidthW-1:0]    len;
  logic [WidthW-1:0]    padn;

  assign out_free = !out_valid_q || out_ready_i;
  assign len      = WidthW'(entry_i.ndig) + WidthW'(entry_i.neg);
  assign padn     = (entry_i.width > len) ? (entry_i.width - len) : '0;

  always_comb begin
    state_d = state_q;
    case (state_q)
      B_IDLE: begin
        if (!qstat_i.empty) begin
          if (padn != '0) begin
            state_d = B_PAD;
          end else begin
            state_d = entry_i.neg ? B_SIGN : B_DIGIT;
          end
        end
      end
      B_PAD: begin
        if (out_free && (pad_cnt_q == PadCntW'(1))) begin
          state_d = cur_q.neg ? B_SIGN : B_DIGIT;
        end
      end
      B_SIGN: begin
        if (out_free) begin
          state_d = B_DIGIT;
        end
      end
      B_DIGIT: begin
        if (out_free && (idx_q == '0)) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
  end

  always_comb begin
    pop_o  = (state_q == B_IDLE) && !qstat_i.empty;
    emit   = (state_q != B_IDLE) && out_free;
    char_d = cur_q.fill_char;
    last_d = 1'b0;
    case (state_q)
      B_PAD:   char_d = cur_q.fill_char;
      B_SIGN:  char_d = CharMinus;
      B_DIGIT: begin
        char_d = digit_char(cur_q.digits[idx_q], cur_q.upper);
        last_d = (idx_q == '0);
      end
      default: char_d = cur_q.fill_char;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_char_o  = out_char_q;
  assign out_last_o  = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      pad_cnt_q   <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (pop_o) begin
        pad_cnt_q <= PadCntW'(padn);
        idx_q     <= entry_i.ndig - NdigW'(1);
      end else if (emit && (state_q == B_PAD)) begin
        pad_cnt_q <= pad_cnt_q - PadCntW'(1);
      end else if (emit && (state_q == B_DIGIT) && (idx_q != '0)) begin
        idx_q <= idx_q - NdigW'(1);
      end
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      cur_q <= entry_i;
    end
    if (emit) begin
      out_char_q <= char_d;
      out_last_q <= last_d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/integer_to_ascii_radix.sv
`default_nettype none

// Converts a 64-bit value to ASCII text in signed decimal, unsigned decimal,
// hex or octal, most significant character first, with pad characters in front
// up to min_width (capped at MAX_WIDTH; in signed decimal the padding precedes
// the minus sign) and tlast on the final character. The front stage takes an
// item, runs decimal values through a binary-to-BCD shift-add-3 unit doing two
// bits per cycle (hex and octal skip this step), then hands the digits to a
// two-entry queue once it has room; it takes no new item before that push. The
// back stage drains the queue and sends one character per cycle while the
// output accepts them, returning to idle after each item's last character.
// Each side stalls on its own, so the front stage can convert the next item
// while the back stage is still sending text.

`include "assert_macros.svh"

module integer_to_ascii_radix import iar_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // value[63:0], min_width[69:64], fill_char[77:70], upper_hex[78], zero[79]
  input  wire logic [79:0] s_axis_tdata,
  // op[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // char_out[7:0]
  output logic [7:0]       m_axis_tdata,
  output logic             m_axis_tlast
);

  logic   push;
  logic   pop;
  entry_t push_entry;
  entry_t pop_entry;
  qstat_t qstat;

  iar_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .op_i        (s_axis_tuser),
    .value_i     (s_axis_tdata[63:0]),
    .min_width_i (s_axis_tdata[69:64]),
    .fill_char_i (s_axis_tdata[77:70]),
    .upper_hex_i (s_axis_tdata[78]),
    .qstat_i     (qstat),
    .push_o      (push),
    .entry_o     (push_entry)
  );

  iar_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .pop_i   (pop),
    .entry_o (pop_entry),
    .qstat_o (qstat)
  );

  iar_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qstat_i     (qstat),
    .pop_o       (pop),
    .entry_i     (pop_entry),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_char_o  (m_axis_tdata),
    .out_last_o  (m_axis_tlast)
  );

  `IAR_ASSERT(a_push_not_full, push |-> !qstat.full)
  `IAR_ASSERT(a_pop_not_empty, pop |-> !qstat.empty)
  `IAR_ASSERT(a_qstat_exclusive, !(qstat.full && qstat.empty))

endmodule

`default_nettype wire

>>> verif/tb_integer_to_ascii_radix.sv
module tb_integer_to_ascii_radix;
  import iar_pkg::*;

  localparam int unsigned TextWidthCap = 32;
  localparam int unsigned DrainCycles = 60;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             last;
  } text_char_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  // value[63:0], min_width[69:64], fill_char[77:70], upper_hex[78], zero[79]
  logic [79:0]       s_axis_tdata = '0;
  // op[1:0]
  logic [1:0]        s_axis_tuser = '0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  // char_out[7:0]
  logic [CharW-1:0]  m_axis_tdata;
  logic              m_axis_tlast;

  text_char_t        expected_chars[$];
  bit                idle_on = 1'b0;
  int unsigned       fail_count = 0;
  int unsigned       chars_checked = 0;
  int unsigned       values_sent = 0;
  int unsigned       op_count[4] = '{default: 0};

  integer_to_ascii_radix #(.MAX_WIDTH(TextWidthCap)) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400000;
    $display("[integer_to_ascii_radix] ERROR");
    $finish;
  end

  // Build the padded text, most significant character first
  function automatic void format_number(op_e op, logic [ValueW-1:0] value,
                                        logic [WidthW-1:0] width, logic [CharW-1:0] pad,
                                        logic upper);
    logic [ValueW-1:0] mag;
    logic [ValueW-1:0] radix;
    logic [ValueW-1:0] d;
    logic [CharW-1:0]  digits[$];
    logic              negative;
    int unsigned       cap;
    int unsigned       pad_count;
    int unsigned       total;
    int unsigned       k;
    int                i;
    radix = (op == OP_HEX) ? 64'd16 : (op == OP_OCT) ? 64'd8 : 64'd10;
    negative = (op == OP_SDEC) && value[ValueW-1];
    mag = negative ? (~value + 64'd1) : value;
    if (mag == '0) begin
      digits.push_back(CharZero);
    end
    while (mag != '0) begin
      d = mag % radix;
      if (d > 64'd9) begin
        digits.push_back(CharW'(d - 64'd10) + (upper ? CharUpA : CharLowA));
      end else begin
        digits.push_back(CharZero + CharW'(d));
      end
      mag = mag / radix;
    end
    if (negative) begin
      digits.push_back(CharMinus);
    end
    cap = (width > TextWidthCap) ? TextWidthCap : int'(width);
    pad_count = (digits.size() < cap) ? cap - digits.size() : 0;
    total = pad_count + digits.size();
    k = 0;
    repeat (pad_count) begin
      k++;
      expected_chars.push_back('{ch: pad, last: (k == total)});
    end
    for (i = digits.size() - 1; i >= 0; i--) begin
      k++;
      expected_chars.push_back('{ch: digits[i], last: (k == total)});
    end
  endfunction

  task automatic send_conversion(op_e op, logic [ValueW-1:0] value,
                                 logic [WidthW-1:0] width, logic [CharW-1:0] pad,
                                 logic upper);
    if (idle_on) begin
      while ($urandom_range(99) < 10) begin
        s_axis_tvalid <= 1'b0;
        @(posedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {1'b0, upper, pad, width, value};
    do @(posedge clk_i); while (!s_axis_tready);
    format_number(op, value, width, pad, upper);
    values_sent++;
    op_count[op]++;
  endtask

  // Drain characters, stall the output now and then
  always @(posedge clk_i) begin : check_output
    text_char_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      chars_checked++;
      if (expected_chars.size() == 0) begin
        $error("unexpected character: char_out %h last %b", m_axis_tdata, m_axis_tlast);
        fail_count++;
      end else begin
        want = expected_chars.pop_front();
        if (m_axis_tdata !== want.ch) begin
          $error("char_out: expected %h, got %h", want.ch, m_axis_tdata);
          fail_count++;
        end
        if (m_axis_tlast !== want.last) begin
          $error("last: expected %b, got %b", want.last, m_axis_tlast);
          fail_count++;
        end
      end
    end
    m_axis_tready <= !(idle_on && $urandom_range(99) < 10);
  end

  task automatic test_extremes();
    op_e op;
    for (int o = 0; o < 4; o++) begin
      op = op_e'(o);
      send_conversion(op, '0, 6'd0, " ", 1'b0);
      send_conversion(op, '1, 6'd0, " ", 1'b1);
    end
    send_conversion(OP_SDEC, 64'h8000_0000_0000_0000, 6'd0, " ", 1'b0);
    send_conversion(OP_UDEC, 64'h8000_0000_0000_0000, 6'd0, " ", 1'b0);
    send_conversion(OP_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0, " ", 1'b0);
    send_conversion(OP_HEX, 64'hFEDC_BA98_7654_3210, 6'd0, " ", 1'b0);
    send_conversion(OP_HEX, 64'hFEDC_BA98_7654_3210, 6'd0, " ", 1'b1);
    send_conversion(OP_OCT, 64'o1234567, 6'd0, " ", 1'b1);
  endtask

  task automatic test_padding();
    send_conversion(OP_SDEC, -64'sd42, 6'd8, " ", 1'b0);
    send_conversion(OP_SDEC, -64'sd42, 6'd8, "0", 1'b0);
    send_conversion(OP_UDEC, 64'd7, 6'd32, "0", 1'b0);
    send_conversion(OP_UDEC, 64'd7, 6'd33, " ", 1'b0);
    send_conversion(OP_HEX, 64'hABC, 6'd63, 8'hFF, 1'b1);
    send_conversion(OP_OCT, 64'd8, 6'd1, 8'h00, 1'b0);
    send_conversion(OP_SDEC, 64'h8000_0000_0000_0000, 6'd21, "*", 1'b0);
    send_conversion(OP_UDEC, '1, 6'd20, "#", 1'b1);
    send_conversion(OP_OCT, '1, 6'd23, "_", 1'b0);
  endtask

  task automatic test_random(int unsigned count);
    logic [ValueW-1:0] value;
    logic [WidthW-1:0] width;
    for (int n = 0; n < count; n++) begin
      // hold off idling for the first stretch
      idle_on = (n >= 40);
      case ($urandom_range(5))
        0: value = {$urandom, $urandom};
        1: value = 64'($urandom_range(20));
        2: value = {$urandom, $urandom} >> $urandom_range(63);
        3: value = -64'($urandom_range(1000));
        4: value = (64'd1 << $urandom_range(63)) - 64'($urandom_range(1));
        default: value = {1'($urandom_range(1)), 63'd0} ^
                         {1'b0, {63{$urandom_range(1) == 1}}};
      endcase
      width = ($urandom_range(9) == 0) ? 6'($urandom_range(33, 63)) : 6'($urandom_range(32));
      send_conversion(op_e'($urandom_range(3)), value, width, 8'($urandom_range(255)),
                      1'($urandom_range(1)));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_on = 1'b1;
    test_extremes();
    test_padding();
    test_random(107);
    s_axis_tvalid <= 1'b0;
    idle_on = 1'b1;
    while (expected_chars.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    $display("converted %0d values: %0d signed dec, %0d unsigned dec, %0d hex, %0d octal",
             values_sent, op_count[OP_SDEC], op_count[OP_UDEC], op_count[OP_HEX],
             op_count[OP_OCT]);
    $display("checked %0d characters including padding, signs and widths past the cap",
             chars_checked);
    if (fail_count == 0) begin
      $display("[integer_to_ascii_radix] OK");
    end else begin
      $display("[integer_to_ascii_radix] ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl/core
rtl/core/iar_pkg.sv
rtl/core/iar_front.sv
rtl/core/iar_fifo.sv
rtl/core/iar_back.sv
rtl/core/integer_to_ascii_radix.sv
verif/tb_integer_to_ascii_radix.sv
